// ----- rtl/core/joystick_report_decoder_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the joystick report decoder core
// Property checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_REPORT_DECODER_CORE_DEFINES_SVH
`define JOYSTICK_REPORT_DECODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define JRD_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("%m: same-cycle check failed");
`define JRD_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("%m: next-cycle check failed");
`else
`define JRD_ASSERT_SAME(label, clk, rst, cond, expr)
`define JRD_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

// ----- rtl/core/jrd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick report decoder package
// Event codes and the event record passed from the parser to the output stage.
// ----------------------------------------------------------------------------
package jrd_pkg;

   localparam logic [1:0] KIND_STICK   = 2'd0;
   localparam logic [1:0] KIND_BUTTON  = 2'd1;
   localparam logic [1:0] KIND_BATTERY = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  raw_x;
      logic [7:0]  raw_y;
      logic [7:0]  button_code;
      logic        pressed;
      logic [15:0] millivolts;
      logic [6:0]  volts;
   } jrd_event_type;

endpackage

// ----- rtl/core/jrd_channel_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick report decoder channels
// Valid/ready channels for received bytes and for decoded events.
// ----------------------------------------------------------------------------
interface jrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface jrd_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        event_kind;
   logic [7:0]        raw_x;
   logic [7:0]        raw_y;
   logic signed [7:0] scaled_x;
   logic signed [7:0] scaled_y;
   logic [7:0]        button_code;
   logic              pressed;
   logic [6:0]        volts;
   logic [9:0]        millivolt_rest;

   modport source (output valid, output event_kind, output raw_x, output raw_y,
                   output scaled_x, output scaled_y, output button_code,
                   output pressed, output volts, output millivolt_rest,
                   input ready);
   modport sink (input valid, input event_kind, input raw_x, input raw_y,
                 input scaled_x, input scaled_y, input button_code,
                 input pressed, input volts, input millivolt_rest,
                 output ready);
endinterface

// ----- rtl/core/jrd_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick report parser
// Tracks the header and payload of each report and registers one event record
// on the last payload byte of a valid report, at most one per report.
// ----------------------------------------------------------------------------
module jrd_parser
   import jrd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   jrd_req_if.sink       req_chan,
   output logic          ev_valid,
   output jrd_event_type ev,
   input  logic          ev_ready
);

   localparam logic [1:0] PH_LENGTH  = 2'd0;
   localparam logic [1:0] PH_MAGIC   = 2'd1;
   localparam logic [1:0] PH_TYPE    = 2'd2;
   localparam logic [1:0] PH_PAYLOAD = 2'd3;

   localparam logic [7:0] MAGIC_BYTE   = 8'hA1;
   localparam logic [7:0] NO_BUTTON    = 8'hFE;
   localparam logic [7:0] TYPE_BUTTON  = 8'd7;
   localparam logic [7:0] TYPE_STICK   = 8'd8;
   localparam logic [7:0] TYPE_BATTERY = 8'd17;
   localparam logic [7:0] LEN_STICK    = 8'd3;
   localparam logic [7:0] LEN_BUTTON   = 8'd6;
   localparam logic [7:0] LEN_BATTERY  = 8'd2;
   localparam logic [7:0] HEADER_TAIL  = 8'd2;
   localparam logic [7:0] PAYLOAD_KEEP = 8'd3;
   localparam int         MV_SHIFT     = 20;
   localparam logic [26:0] MV_RECIP    = 27'd8389;

   logic [1:0]    phase_ff, phase_in;
   logic [7:0]    len_ff, len_in;
   logic          magic_ok_ff, magic_ok_in;
   logic [7:0]    type_ff, type_in;
   logic [7:0]    remain_ff, remain_in;
   logic [7:0]    held_ff, held_in;
   logic [7:0]    pb_ff [3];
   logic          ev_valid_ff, ev_valid_in;
   jrd_event_type ev_ff, ev_in;

   logic          accept;
   logic [7:0]    plen;
   logic [7:0]    idx;
   logic          pb_write;
   logic [15:0]   mv;
   logic [26:0]   mv_prod;
   logic [7:0]    b;

   assign req_chan.ready = !ev_valid_ff || ev_ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.rx_byte;
   assign plen           = len_ff - HEADER_TAIL;
   assign idx            = plen - remain_ff;
   assign pb_write       = accept && (phase_ff == PH_PAYLOAD) && (idx < PAYLOAD_KEEP);
   assign mv             = {pb_ff[0], b};
   assign mv_prod        = 27'(mv[15:3]) * MV_RECIP;

   always_comb begin
      phase_in    = phase_ff;
      len_in      = len_ff;
      magic_ok_in = magic_ok_ff;
      type_in     = type_ff;
      remain_in   = remain_ff;
      held_in     = held_ff;
      ev_valid_in = ev_valid_ff && !ev_ready;
      ev_in       = ev_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_LENGTH: begin
               len_in   = b;
               phase_in = PH_MAGIC;
            end
            PH_MAGIC: begin
               magic_ok_in = (b == MAGIC_BYTE);
               phase_in    = PH_TYPE;
            end
            PH_TYPE: begin
               type_in = b;
               if (!magic_ok_ff || len_ff <= HEADER_TAIL) begin
                  phase_in = PH_LENGTH;
               end else begin
                  remain_in = plen;
                  phase_in  = PH_PAYLOAD;
               end
            end
            default: begin
               if (remain_ff != 8'd0) begin
                  remain_in = remain_ff - 8'd1;
               end
               if (remain_ff <= 8'd1) begin
                  phase_in = PH_LENGTH;
                  ev_in    = '0;
                  priority if (type_ff == TYPE_STICK && plen == LEN_STICK) begin
                     if (pb_ff[0] == 8'd0) begin
                        ev_valid_in = 1'b1;
                        ev_in.kind  = KIND_STICK;
                        ev_in.raw_x = pb_ff[1];
                        ev_in.raw_y = b;
                     end
                  end else if (type_ff == TYPE_BUTTON && plen == LEN_BUTTON) begin
                     if (pb_ff[0] != NO_BUTTON) begin
                        held_in = pb_ff[0];
                     end
                     ev_valid_in       = 1'b1;
                     ev_in.kind        = KIND_BUTTON;
                     ev_in.button_code = (pb_ff[0] != NO_BUTTON) ? pb_ff[0] : held_ff;
                     ev_in.pressed     = (pb_ff[0] != NO_BUTTON);
                  end else if (type_ff == TYPE_BATTERY && plen == LEN_BATTERY) begin
                     ev_valid_in      = 1'b1;
                     ev_in.kind       = KIND_BATTERY;
                     ev_in.millivolts = mv;
                     ev_in.volts      = mv_prod[MV_SHIFT+6:MV_SHIFT];
                  end else begin
                     ev_in = ev_ff;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LENGTH;
         len_ff      <= '0;
         magic_ok_ff <= 1'b0;
         type_ff     <= '0;
         remain_ff   <= '0;
         held_ff     <= '0;
         ev_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         len_ff      <= len_in;
         magic_ok_ff <= magic_ok_in;
         type_ff     <= type_in;
         remain_ff   <= remain_in;
         held_ff     <= held_in;
         ev_valid_ff <= ev_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff <= ev_in;
      if (pb_write) begin
         pb_ff[idx[1:0]] <= b;
      end
   end

   assign ev_valid = ev_valid_ff;
   assign ev       = ev_ff;

endmodule

// ----- rtl/core/jrd_format.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick event formatter
// Scales stick axes to percent, reduces the battery reading to the millivolts
// beyond the parser's whole volts, and holds the event in the response register.
// ----------------------------------------------------------------------------
module jrd_format
   import jrd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          ev_valid,
   input  jrd_event_type ev,
   output logic          ev_ready,
   jrd_rsp_if.source     rsp_chan
);

   localparam int          AXIS_SHIFT = 14;
   localparam logic [20:0] AXIS_RECIP = 21'd12901;
   localparam logic [15:0] MV_PER_V   = 16'd1000;

   function automatic logic signed [7:0] scale_axis(input logic [7:0] v);
      logic [6:0]  mag;
      logic [20:0] prod;
      logic [7:0]  pct;
      begin
         mag  = v[7] ? ~v[6:0] : v[6:0];
         prod = 21'(mag) * AXIS_RECIP;
         pct  = {1'b0, prod[AXIS_SHIFT+6:AXIS_SHIFT]};
         return v[7] ? $signed(8'd0 - pct) : $signed(pct);
      end
   endfunction

   logic              valid_ff, valid_in;
   logic [1:0]        kind_ff;
   logic [7:0]        raw_x_ff;
   logic [7:0]        raw_y_ff;
   logic signed [7:0] scaled_x_ff;
   logic signed [7:0] scaled_y_ff;
   logic [7:0]        button_ff;
   logic              pressed_ff;
   logic [6:0]        volts_ff;
   logic [9:0]        rest_ff;
   logic [15:0]       rest_full;
   logic              load;

   assign ev_ready  = !valid_ff || rsp_chan.ready;
   assign load      = ev_valid && ev_ready;
   assign valid_in  = load || (valid_ff && !rsp_chan.ready);
   assign rest_full = ev.millivolts - 16'(ev.volts) * MV_PER_V;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff     <= ev.kind;
         raw_x_ff    <= ev.raw_x;
         raw_y_ff    <= ev.raw_y;
         scaled_x_ff <= scale_axis(ev.raw_x);
         scaled_y_ff <= scale_axis(ev.raw_y);
         button_ff   <= ev.button_code;
         pressed_ff  <= ev.pressed;
         volts_ff    <= ev.volts;
         rest_ff     <= rest_full[9:0];
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.event_kind     = kind_ff;
   assign rsp_chan.raw_x          = raw_x_ff;
   assign rsp_chan.raw_y          = raw_y_ff;
   assign rsp_chan.scaled_x       = scaled_x_ff;
   assign rsp_chan.scaled_y       = scaled_y_ff;
   assign rsp_chan.button_code    = button_ff;
   assign rsp_chan.pressed        = pressed_ff;
   assign rsp_chan.volts          = volts_ff;
   assign rsp_chan.millivolt_rest = rest_ff;

endmodule

// ----- rtl/core/joystick_report_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick report decoder core
// Parses a controller byte stream into stick, button and battery events.
// ----------------------------------------------------------------------------
//   channel    direction  payload
//   req_chan   in         rx_byte, one received byte per request
//   rsp_chan   out        event_kind, axes, button, battery fields
//
// One request can be accepted in every cycle unless the parser holds an
// event that the formatter cannot take. An event passes the parser register
// and then the formatter register before it appears on rsp_chan. The two
// registers let the parser keep taking requests while one event waits on a
// stalled response. Synchronous reset returns the parser to the length byte
// and clears the held button code.
// ----------------------------------------------------------------------------
`include "joystick_report_decoder_core_defines.svh"

module joystick_report_decoder_core
   import jrd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   jrd_req_if.sink   req_chan,
   jrd_rsp_if.source rsp_chan
);

   logic          ev_valid;
   logic          ev_ready;
   jrd_event_type ev;

   jrd_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .ev_valid (ev_valid),
      .ev       (ev),
      .ev_ready (ev_ready)
   );

   jrd_format u_format (
      .clock    (clock),
      .reset    (reset),
      .ev_valid (ev_valid),
      .ev       (ev),
      .ev_ready (ev_ready),
      .rsp_chan (rsp_chan)
   );

   `JRD_ASSERT_SAME(a_stall_blocks_req, clock, reset, ev_valid && rsp_chan.valid && !rsp_chan.ready, !req_chan.ready)
   `JRD_ASSERT_NEXT(a_event_handoff, clock, reset, ev_valid && ev_ready, rsp_chan.valid)
   `JRD_ASSERT_SAME(a_rest_range, clock, reset, rsp_chan.valid && rsp_chan.event_kind == KIND_BATTERY, rsp_chan.millivolt_rest < 10'd1000)
   `JRD_ASSERT_SAME(a_axis_range, clock, reset, rsp_chan.valid && rsp_chan.event_kind == KIND_STICK, rsp_chan.scaled_x >= -8'sd100 && rsp_chan.scaled_x <= 8'sd100)

endmodule
